>>> rtl/core/euler_point_transform_core_defines.svh
// Assertion macros for the point transform core.
`ifndef EULER_POINT_TRANSFORM_CORE_DEFINES_SVH
`define EULER_POINT_TRANSFORM_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define EPT_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("point transform check failed");
`define EPT_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("point transform check failed");
`else
`define EPT_ASSERT_NOW(lbl, pre, post)
`define EPT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> rtl/core/ept_pkg.sv
// Shared constants, types and the sine table builder for the point transform core.
package ept_pkg;
	localparam int SINE_DEPTH = 1024;
	localparam int ROM_AW = $clog2(SINE_DEPTH + 1);
	localparam int ROM_DW = 17;
	localparam int TRIG_W = 18;
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	localparam int COORD_W = 46;
	localparam int ANGLE_W = 16;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam logic signed [COORD_W-1:0] SCALED_MAX = COORD_W'(64'sd1 << 40);
	localparam logic signed [COORD_W-1:0] SCALED_MIN = -SCALED_MAX;

	typedef logic [ROM_DW-1:0] sine_rom_t [SINE_DEPTH+1];

	// Unsigned floor quotient by shift and subtract, used only while building the table.
	function automatic longint unsigned div_u64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = 64'd0;
		rem = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			quo = quo << 1;
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | 64'd1;
			end
		end
		return quo;
	endfunction

	// Quarter-wave sine, 1.0 = 65536, from a Taylor series in Q30.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint sum;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			x = div_u64(HALF_PI_Q30 * longint'(k), 64'(SINE_DEPTH));
			x2 = (x * x) >> 30;
			t = x;
			sum = longint'(x);
			for (int n = 1; n <= 12; n++) begin
				t = (t * x2) >> 30;
				t = div_u64(t, longint'((2 * n) * (2 * n + 1)));
				if ((n & 1) == 1) begin
					sum = sum - longint'(t);
				end else begin
					sum = sum + longint'(t);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			rom[k] = ROM_DW'((sum + 8192) >>> 14);
		end
		return rom;
	endfunction
endpackage

>>> rtl/core/ept_trig.sv
// Sine and cosine lookup of one binary angle with a registered table read.
module ept_trig (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [ept_pkg::ANGLE_W-1:0]            angle,
	output logic signed [ept_pkg::TRIG_W-1:0]      sin_val,
	output logic signed [ept_pkg::TRIG_W-1:0]      cos_val
);
	import ept_pkg::*;

	localparam sine_rom_t ROM = build_sine_rom();
	localparam int PW = 14 + ROM_AW + 1;

	logic [ANGLE_W-1:0] cos_angle;
	logic [ROM_AW-1:0]  sin_addr;
	logic [ROM_AW-1:0]  cos_addr;
	logic [ROM_DW-1:0]  sin_mag_s1;
	logic [ROM_DW-1:0]  cos_mag_s1;
	logic               sin_neg_s1;
	logic               cos_neg_s1;

	function automatic logic [ROM_AW-1:0] addr_of(input logic [ANGLE_W-1:0] a);
		logic [PW-1:0]     prod;
		logic [ROM_AW-1:0] idx;
		prod = PW'(a[13:0]) * PW'(SINE_DEPTH);
		idx = ROM_AW'(prod >> 14);
		return a[14] ? ROM_AW'(SINE_DEPTH) - idx : idx;
	endfunction

	assign cos_angle = angle + ANGLE_W'(16384);
	assign sin_addr = addr_of(angle);
	assign cos_addr = addr_of(cos_angle);

	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag_s1 <= ROM[sin_addr];
			cos_mag_s1 <= ROM[cos_addr];
			sin_neg_s1 <= angle[15];
			cos_neg_s1 <= cos_angle[15];
		end
	end

	assign sin_val = sin_neg_s1 ? -$signed(TRIG_W'(sin_mag_s1)) : $signed(TRIG_W'(sin_mag_s1));
	assign cos_val = cos_neg_s1 ? -$signed(TRIG_W'(cos_mag_s1)) : $signed(TRIG_W'(cos_mag_s1));
endmodule

>>> rtl/core/ept_rot.sv
// Two-stage plane rotation: products, then sum and rounding.
module ept_rot (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [ept_pkg::COORD_W-1:0]     a,
	input  logic signed [ept_pkg::COORD_W-1:0]     b,
	input  logic signed [ept_pkg::TRIG_W-1:0]      c,
	input  logic signed [ept_pkg::TRIG_W-1:0]      n,
	output logic signed [ept_pkg::COORD_W-1:0]     a_rot,
	output logic signed [ept_pkg::COORD_W-1:0]     b_rot
);
	import ept_pkg::*;

	localparam int MW = COORD_W + TRIG_W;

	logic signed [MW-1:0] ac_s1;
	logic signed [MW-1:0] bn_s1;
	logic signed [MW-1:0] bc_s1;
	logic signed [MW-1:0] an_s1;
	logic signed [MW:0]   sum_a;
	logic signed [MW:0]   sum_b;

	always_ff @(posedge clk) begin
		if (en) begin
			ac_s1 <= MW'(a) * MW'(c);
			bn_s1 <= MW'(b) * MW'(n);
			bc_s1 <= MW'(b) * MW'(c);
			an_s1 <= MW'(a) * MW'(n);
		end
	end

	// Rounding adds one half and floors, so ties go toward plus infinity.
	assign sum_a = (MW+1)'(ac_s1) + (MW+1)'(bn_s1) + (MW+1)'(32768);
	assign sum_b = (MW+1)'(bc_s1) - (MW+1)'(an_s1) + (MW+1)'(32768);

	always_ff @(posedge clk) begin
		if (en) begin
			a_rot <= COORD_W'(sum_a >>> 16);
			b_rot <= COORD_W'(sum_b >>> 16);
		end
	end
endmodule

>>> rtl/core/euler_point_transform_core.sv
// Top level of the point transform core: scale, three rotations, translate.
// Throughput is one item per cycle; the whole pipeline advances together and
// freezes only while a finished result waits on out_ready.
// The sine table is constant logic, so no clearing pass follows reset.
// Reset clears only the stage valid bits; data registers are not reset.
module euler_point_transform_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [ept_pkg::DATA_W-1:0]    point_x,
	input  logic signed [ept_pkg::DATA_W-1:0]    point_y,
	input  logic signed [ept_pkg::DATA_W-1:0]    point_z,
	input  logic signed [ept_pkg::DATA_W-1:0]    scale_x,
	input  logic signed [ept_pkg::DATA_W-1:0]    scale_y,
	input  logic signed [ept_pkg::DATA_W-1:0]    scale_z,
	input  logic [ept_pkg::ANGLE_W-1:0]          angle_x,
	input  logic [ept_pkg::ANGLE_W-1:0]          angle_y,
	input  logic [ept_pkg::ANGLE_W-1:0]          angle_z,
	input  logic signed [ept_pkg::DATA_W-1:0]    shift_x,
	input  logic signed [ept_pkg::DATA_W-1:0]    shift_y,
	input  logic signed [ept_pkg::DATA_W-1:0]    shift_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [ept_pkg::DATA_W-1:0]    out_x,
	output logic signed [ept_pkg::DATA_W-1:0]    out_y,
	output logic signed [ept_pkg::DATA_W-1:0]    out_z,
	output logic                                 overflow
);
	import ept_pkg::*;
	`include "euler_point_transform_core_defines.svh"

	localparam int NST = 9;
	localparam int SW = DATA_W + 16;

	logic [NST-1:0] vld_q;
	logic           en;

	logic signed [PROD_W-1:0] px_s1, py_s1, pz_s1;
	logic signed [SW-1:0]     rx, ry, rz;
	logic signed [COORD_W-1:0] x_s2, y_s2, z_s2;
	logic                     ovf_s2;
	logic                     clx, cly, clz;

	logic signed [TRIG_W-1:0] sz, cz, sy, cy, sx, cx;
	logic signed [TRIG_W-1:0] sy_s [2:4];
	logic signed [TRIG_W-1:0] cy_s [2:4];
	logic signed [TRIG_W-1:0] sx_s [2:6];
	logic signed [TRIG_W-1:0] cx_s [2:6];
	logic signed [DATA_W-1:0] shx_s [1:8];
	logic signed [DATA_W-1:0] shy_s [1:8];
	logic signed [DATA_W-1:0] shz_s [1:8];
	logic                     ovf_s [3:8];

	logic signed [COORD_W-1:0] x_s4, y_s4, z_s4, z_s3;
	logic signed [COORD_W-1:0] y_s5;
	logic signed [COORD_W-1:0] x_s6, y_s6, z_s6;
	logic signed [COORD_W-1:0] x_s7, x_s8, y_s8, z_s8;

	logic signed [COORD_W:0] fx, fy, fz;
	logic                    sat_x, sat_y, sat_z;

	function automatic logic signed [COORD_W-1:0] clamp_scaled(input logic signed [SW-1:0] v);
		if (v > SW'(SCALED_MAX)) begin
			return SCALED_MAX;
		end else if (v < SW'(SCALED_MIN)) begin
			return SCALED_MIN;
		end
		return COORD_W'(v);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [COORD_W:0] v);
		if (v > (COORD_W+1)'(64'sd2147483647)) begin
			return DATA_W'(32'h7fffffff);
		end else if (v < -(COORD_W+1)'(64'sd2147483648)) begin
			return DATA_W'(32'h80000000);
		end
		return DATA_W'(v);
	endfunction

	assign en = !vld_q[NST-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	// Stage 1: scale products and table reads.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= PROD_W'(point_x) * PROD_W'(scale_x);
			py_s1 <= PROD_W'(point_y) * PROD_W'(scale_y);
			pz_s1 <= PROD_W'(point_z) * PROD_W'(scale_z);
			shx_s[1] <= shift_x;
			shy_s[1] <= shift_y;
			shz_s[1] <= shift_z;
		end
	end

	ept_trig u_trig_z (.clk(clk), .en(en), .angle(angle_z), .sin_val(sz), .cos_val(cz));
	ept_trig u_trig_y (.clk(clk), .en(en), .angle(angle_y), .sin_val(sy), .cos_val(cy));
	ept_trig u_trig_x (.clk(clk), .en(en), .angle(angle_x), .sin_val(sx), .cos_val(cx));

	// Stage 2: round the scaled point and clamp it to plus or minus 2^40.
	assign rx = SW'((px_s1 + PROD_W'(32768)) >>> 16);
	assign ry = SW'((py_s1 + PROD_W'(32768)) >>> 16);
	assign rz = SW'((pz_s1 + PROD_W'(32768)) >>> 16);
	assign clx = (rx > SW'(SCALED_MAX)) || (rx < SW'(SCALED_MIN));
	assign cly = (ry > SW'(SCALED_MAX)) || (ry < SW'(SCALED_MIN));
	assign clz = (rz > SW'(SCALED_MAX)) || (rz < SW'(SCALED_MIN));

	logic signed [TRIG_W-1:0] sz_s2, cz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= clamp_scaled(rx);
			y_s2 <= clamp_scaled(ry);
			z_s2 <= clamp_scaled(rz);
			ovf_s2 <= clx || cly || clz;
			sz_s2 <= sz;
			cz_s2 <= cz;
			sy_s[2] <= sy;
			cy_s[2] <= cy;
			sx_s[2] <= sx;
			cx_s[2] <= cx;
			shx_s[2] <= shx_s[1];
			shy_s[2] <= shy_s[1];
			shz_s[2] <= shz_s[1];
		end
	end

	// Delay lines for the values each later stage needs.
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[3] <= ovf_s2;
			for (int i = 4; i <= 8; i++) begin
				ovf_s[i] <= ovf_s[i-1];
			end
			for (int i = 3; i <= 8; i++) begin
				shx_s[i] <= shx_s[i-1];
				shy_s[i] <= shy_s[i-1];
				shz_s[i] <= shz_s[i-1];
			end
			for (int i = 3; i <= 4; i++) begin
				sy_s[i] <= sy_s[i-1];
				cy_s[i] <= cy_s[i-1];
			end
			for (int i = 3; i <= 6; i++) begin
				sx_s[i] <= sx_s[i-1];
				cx_s[i] <= cx_s[i-1];
			end
			z_s3 <= z_s2;
			z_s4 <= z_s3;
			y_s5 <= y_s4;
			y_s6 <= y_s5;
			x_s7 <= x_s6;
			x_s8 <= x_s7;
		end
	end

	ept_rot u_rot_z (
		.clk(clk), .en(en), .a(x_s2), .b(y_s2), .c(cz_s2), .n(sz_s2),
		.a_rot(x_s4), .b_rot(y_s4)
	);

	ept_rot u_rot_y (
		.clk(clk), .en(en), .a(x_s4), .b(z_s4), .c(cy_s[4]), .n(sy_s[4]),
		.a_rot(x_s6), .b_rot(z_s6)
	);

	ept_rot u_rot_x (
		.clk(clk), .en(en), .a(y_s6), .b(z_s6), .c(cx_s[6]), .n(sx_s[6]),
		.a_rot(y_s8), .b_rot(z_s8)
	);

	// Stage 9: translate and saturate into the output register.
	assign fx = (COORD_W+1)'(x_s8) + (COORD_W+1)'(shx_s[8]);
	assign fy = (COORD_W+1)'(y_s8) + (COORD_W+1)'(shy_s[8]);
	assign fz = (COORD_W+1)'(z_s8) + (COORD_W+1)'(shz_s[8]);
	assign sat_x = (fx != (COORD_W+1)'(sat32(fx)));
	assign sat_y = (fy != (COORD_W+1)'(sat32(fy)));
	assign sat_z = (fz != (COORD_W+1)'(sat32(fz)));

	always_ff @(posedge clk) begin
		if (en) begin
			out_x <= sat32(fx);
			out_y <= sat32(fy);
			out_z <= sat32(fz);
			overflow <= ovf_s[8] || sat_x || sat_y || sat_z;
		end
	end

	`EPT_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_q))
	`EPT_ASSERT_NEXT(a_item_moves, en && vld_q[0], vld_q[1])
	`EPT_ASSERT_NEXT(a_sat_flags, en && vld_q[NST-2] && (sat_x || sat_y || sat_z), overflow)
	`EPT_ASSERT_NOW(a_ready_when_empty, !vld_q[NST-1], in_ready)
endmodule
